### src/dpb_pkg.sv
// Package for the depth pixel back-projection block.
// Payload types, register indexes, controller/datapath command and status types.
// No dependencies.
package dpb_pkg;

    localparam int DEF_SUBSAMPLE_STEP = 4;
    localparam int DEF_MAX_COLUMNS    = 4096;

    localparam int DEPTH_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int POINT_W   = 24;
    localparam int WIDTH_W   = 13;
    localparam int PRINC_W   = 16;
    localparam int COEF_W    = 24;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [COORD_W-1:0] ROW_MAX = 12'd4095;

    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [PRINC_W-1:0] RST_PRINCIPAL_X     = 16'd5112;
    localparam logic [PRINC_W-1:0] RST_PRINCIPAL_Y     = 16'd3832;
    localparam logic [COEF_W-1:0]  RST_INV_FOCAL_X     = 24'd31957;
    localparam logic [COEF_W-1:0]  RST_INV_FOCAL_Y     = 24'd31957;
    localparam logic [COEF_W-1:0]  RST_INV_DEPTH_SCALE = 24'd16777;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_PRINCIPAL_X     = 3'd1,
        REG_PRINCIPAL_Y     = 3'd2,
        REG_INV_FOCAL_X     = 3'd3,
        REG_INV_FOCAL_Y     = 3'd4,
        REG_INV_DEPTH_SCALE = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MS_DEPTH = 2'd0,   // depth * inv_depth_scale
        MS_MAG   = 2'd1,   // offset magnitude * z
        MS_LO    = 2'd2,   // low 24 bits of previous product * inv_focal
        MS_HI    = 2'd3    // saved high 16 bits * inv_focal
    } t_mul_sel;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_raw;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               frame_start;
    } t_pixel;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [POINT_W-1:0]        point_z;
        logic [COLOR_W-1:0]        out_blue;
        logic [COLOR_W-1:0]        out_green;
        logic [COLOR_W-1:0]        out_red;
    } t_point;

    typedef struct packed {
        logic     accept;
        t_mul_sel mul_sel;
        logic     axis;      // 0: x, 1: y
        logic     hi_load;
        logic     acc_load;
        logic     acc_add;
        logic     z_load;
        logic     res_load;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic out_busy;
    } t_dp_sts;

endpackage

### src/dpb_if.sv
// Valid/ready channel interfaces for pixels in and points out.
// Depends on dpb_pkg for the payload types.
interface dpb_pixel_if;
    logic           valid;
    logic           ready;
    dpb_pkg::t_pixel data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dpb_point_if;
    logic           valid;
    logic           ready;
    dpb_pkg::t_point data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/dpb_ctrl.sv
// Sequencer for the back-projection datapath: steps the shared multiplier
// through z, then x, then y. Depends on dpb_pkg.
module dpb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dpb_pkg::t_dp_sts i_sts,
    output dpb_pkg::t_dp_cmd o_cmd
);
    import dpb_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_ZMUL = 9'b000000010,
        ST_ZSAT = 9'b000000100,
        ST_MAG  = 9'b000001000,
        ST_LO   = 9'b000010000,
        ST_HI   = 9'b000100000,
        ST_SUM  = 9'b001000000,
        ST_RND  = 9'b010000000,
        ST_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    always_comb begin
        n_state       = r_state;
        n_axis        = r_axis;
        o_cmd         = '0;
        o_cmd.mul_sel = MS_DEPTH;
        o_cmd.axis    = r_axis;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.hit) begin
                    n_state = ST_ZMUL;
                    n_axis  = 1'b0;
                end
            end
            ST_ZMUL: begin
                o_cmd.mul_sel = MS_DEPTH;
                n_state       = ST_ZSAT;
            end
            ST_ZSAT: begin
                o_cmd.z_load = 1'b1;
                n_state      = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mul_sel = MS_MAG;
                n_state       = ST_LO;
            end
            ST_LO: begin
                o_cmd.mul_sel = MS_LO;
                o_cmd.hi_load = 1'b1;
                n_state       = ST_HI;
            end
            ST_HI: begin
                o_cmd.mul_sel  = MS_HI;
                o_cmd.acc_load = 1'b1;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_RND;
            end
            ST_RND: begin
                o_cmd.res_load = 1'b1;
                if (r_axis) begin
                    n_state = ST_DONE;
                end else begin
                    n_axis  = 1'b1;
                    n_state = ST_MAG;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    a_hit_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_sts.hit) |=> (r_state == ST_ZMUL))
        else $error("hit request did not start the sequence");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.out_load && i_sts.out_busy))
        else $error("output register loaded while still held");

    a_y_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND && r_axis) |=> (r_state == ST_DONE))
        else $error("y rounding not followed by done");

    a_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RND && !r_axis) |=> (r_state == ST_MAG && r_axis))
        else $error("x rounding not followed by y pass");

endmodule

### src/dpb_dp.sv
// Datapath: config registers, raster counters, shared 24x24 multiplier,
// accumulator, rounding/saturation and output register. Depends on dpb_pkg.
module dpb_dp #(
    parameter int SUBSAMPLE_STEP = dpb_pkg::DEF_SUBSAMPLE_STEP,
    parameter int MAX_COLUMNS    = dpb_pkg::DEF_MAX_COLUMNS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpb_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  dpb_pkg::t_pixel                     i_pixel,
    input  dpb_pkg::t_dp_cmd                    i_cmd,
    output dpb_pkg::t_dp_sts                    o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dpb_pkg::t_point                     o_point
);
    import dpb_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int PH_W  = (SUBSAMPLE_STEP > 1) ? $clog2(SUBSAMPLE_STEP) : 1;
    localparam logic [PH_W-1:0]    PH_LAST = PH_W'(SUBSAMPLE_STEP - 1);
    localparam logic [WIDTH_W-1:0] LIM_MAX = WIDTH_W'(MAX_COLUMNS);

    // configuration
    logic [WIDTH_W-1:0] r_width;
    logic [PRINC_W-1:0] r_px, r_py;
    logic [COEF_W-1:0]  r_fx, r_fy, r_ids;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RST_IMAGE_WIDTH;
            r_px    <= RST_PRINCIPAL_X;
            r_py    <= RST_PRINCIPAL_Y;
            r_fx    <= RST_INV_FOCAL_X;
            r_fy    <= RST_INV_FOCAL_Y;
            r_ids   <= RST_INV_DEPTH_SCALE;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:     r_width <= i_cfg_data[WIDTH_W-1:0];
                REG_PRINCIPAL_X:     r_px    <= i_cfg_data[PRINC_W-1:0];
                REG_PRINCIPAL_Y:     r_py    <= i_cfg_data[PRINC_W-1:0];
                REG_INV_FOCAL_X:     r_fx    <= i_cfg_data[COEF_W-1:0];
                REG_INV_FOCAL_Y:     r_fy    <= i_cfg_data[COEF_W-1:0];
                REG_INV_DEPTH_SCALE: r_ids   <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position; phase counters track position mod the subsample step
    logic [COL_W-1:0]   r_col, n_col, col_cur;
    logic [COORD_W-1:0] r_row, n_row, row_cur;
    logic [PH_W-1:0]    r_col_ph, n_col_ph, col_ph_cur;
    logic [PH_W-1:0]    r_row_ph, n_row_ph, row_ph_cur;
    logic [WIDTH_W-1:0] limit;
    logic               wrap;

    always_comb begin
        col_cur    = i_pixel.frame_start ? '0 : r_col;
        row_cur    = i_pixel.frame_start ? '0 : r_row;
        col_ph_cur = i_pixel.frame_start ? '0 : r_col_ph;
        row_ph_cur = i_pixel.frame_start ? '0 : r_row_ph;

        if (r_width == '0) begin
            limit = WIDTH_W'(1);
        end else if (r_width > LIM_MAX) begin
            limit = LIM_MAX;
        end else begin
            limit = r_width;
        end
        wrap = (WIDTH_W'(col_cur) + WIDTH_W'(1)) >= limit;

        n_row    = row_cur;
        n_row_ph = row_ph_cur;
        if (wrap) begin
            n_col    = '0;
            n_col_ph = '0;
            if (row_cur < ROW_MAX) begin
                n_row    = row_cur + COORD_W'(1);
                n_row_ph = (row_ph_cur == PH_LAST) ? '0 : row_ph_cur + PH_W'(1);
            end
        end else begin
            n_col    = col_cur + COL_W'(1);
            n_col_ph = (col_ph_cur == PH_LAST) ? '0 : col_ph_cur + PH_W'(1);
        end
    end

    assign o_sts.hit = (i_pixel.depth_raw != '0) && (col_ph_cur == '0) && (row_ph_cur == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else if (i_cmd.accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

    // request payload held for the sequence
    logic [DEPTH_W-1:0] r_depth;
    logic [COLOR_W-1:0] r_blue, r_green, r_red;
    logic [COORD_W-1:0] r_pcol, r_prow;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_depth <= i_pixel.depth_raw;
            r_blue  <= i_pixel.blue;
            r_green <= i_pixel.green;
            r_red   <= i_pixel.red;
            r_pcol  <= COORD_W'(col_cur);
            r_prow  <= row_cur;
        end
    end

    // signed offset in Q.4 pixels, as sign and magnitude
    logic [PRINC_W-1:0] p4, princ, mag;
    logic               neg;
    logic [COEF_W-1:0]  focal;

    always_comb begin
        p4    = i_cmd.axis ? {r_prow, 4'b0} : {r_pcol, 4'b0};
        princ = i_cmd.axis ? r_py : r_px;
        focal = i_cmd.axis ? r_fy : r_fx;
        neg   = p4 < princ;
        mag   = neg ? (princ - p4) : (p4 - princ);
    end

    // shared multiplier
    logic [COEF_W-1:0]   mul_a, mul_b;
    logic [2*COEF_W-1:0] mul_p, r_prod;
    logic [15:0]         r_mz_hi;
    logic [63:0]         r_acc;
    logic [POINT_W-1:0]  r_z;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_DEPTH: begin
                mul_a = COEF_W'(r_depth);
                mul_b = r_ids;
            end
            MS_MAG: begin
                mul_a = COEF_W'(mag);
                mul_b = r_z;
            end
            MS_LO: begin
                mul_a = r_prod[23:0];
                mul_b = focal;
            end
            MS_HI: begin
                mul_a = COEF_W'(r_mz_hi);
                mul_b = focal;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // z rounding and saturation
    logic [40:0]        z_sum;
    logic [POINT_W-1:0] z_sat;
    // x/y rounding half away from zero, then saturation
    logic [64:0]        rnd_sum;
    logic [36:0]        q;
    logic [POINT_W-1:0] q_sat, axis_res;

    always_comb begin
        z_sum = {1'b0, r_prod[39:0]} + 41'd128;
        z_sat = (|z_sum[40:32]) ? {POINT_W{1'b1}} : z_sum[31:8];

        rnd_sum = {1'b0, r_acc} + 65'(64'd1 << 27);
        q       = rnd_sum[64:28];
        if (neg) begin
            q_sat    = (q > 37'd8388608) ? 24'd8388608 : q[23:0];
            axis_res = ~q_sat + 24'd1;
        end else begin
            q_sat    = (q > 37'd8388607) ? 24'd8388607 : q[23:0];
            axis_res = q_sat;
        end
    end

    logic signed [POINT_W-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.hi_load) begin
            r_mz_hi <= r_prod[39:24];
        end
        if (i_cmd.acc_load) begin
            r_acc <= 64'(r_prod);
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {r_prod[39:0], 24'b0};
        end
        if (i_cmd.z_load) begin
            r_z <= z_sat;
        end
        if (i_cmd.res_load) begin
            if (i_cmd.axis) begin
                r_y <= axis_res;
            end else begin
                r_x <= axis_res;
            end
        end
    end

    // output register
    t_point r_out;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.point_x   <= r_x;
            r_out.point_y   <= r_y;
            r_out.point_z   <= r_z;
            r_out.out_blue  <= r_blue;
            r_out.out_green <= r_green;
            r_out.out_red   <= r_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_point        = r_out;

    a_zero_z_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.point_z != '0 || (r_out.point_x == '0 && r_out.point_y == '0)))
        else $error("zero depth point with nonzero x or y");

    a_col_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0) |-> (r_col_ph == '0))
        else $error("column phase out of step with column");

endmodule

### src/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block.
// Depends on dpb_pkg, dpb_if (channels), dpb_ctrl and dpb_dp.
//
//  port     | dir | handshake     | carries
//  i_pix    | in  | valid/ready   | depth_raw, blue, green, red, frame_start
//  o_pts    | out | valid/ready   | point_x, point_y, point_z, out_blue/green/red
//  i_cfg_*  | in  | write enable  | register index and data, no read-back
//
// A pixel that produces no point leaves the sequencer idle; the next pixel
// is taken in the following cycle. For a point pixel, one shared 24x24
// multiplier is stepped through z, then x and y (five steps per axis).
// The finished point sits in an output register; a new pixel is taken only
// after the point is moved there, so a stalled output holds the sequencer.
// Reset is synchronous, active low, and restores register defaults.
module depth_pixel_backprojection #(
    parameter int SUBSAMPLE_STEP = dpb_pkg::DEF_SUBSAMPLE_STEP,
    parameter int MAX_COLUMNS    = dpb_pkg::DEF_MAX_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    dpb_pixel_if.sink                     i_pix,
    dpb_point_if.source                   o_pts
);
    import dpb_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dpb_dp #(
        .SUBSAMPLE_STEP (SUBSAMPLE_STEP),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_pix.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_pts.valid),
        .i_out_ready (o_pts.ready),
        .o_point     (o_pts.data)
    );

endmodule

### tb/dpb_checker.sv
// Scoreboard for the depth pixel back-projection block.
// Follows register writes and pixel requests, predicts each point and checks it against
// the point channel. Depends on dpb_pkg and the channel interfaces in dpb_if.
module dpb_checker #(
    parameter int SUBSAMPLE_STEP = dpb_pkg::DEF_SUBSAMPLE_STEP,
    parameter int MAX_COLUMNS    = dpb_pkg::DEF_MAX_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dpb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    dpb_pixel_if                          i_pix,
    dpb_point_if                          i_pts,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_points
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpb_pkg::*;

    localparam int ROUND_SHIFT = 28;    // Q.44 product down to Q.16
    localparam logic [65:0] POS_SAT = 66'd8388607;
    localparam logic [65:0] NEG_SAT = 66'd8388608;

    logic [WIDTH_W-1:0] cfg_width;
    logic [PRINC_W-1:0] cfg_cx;
    logic [PRINC_W-1:0] cfg_cy;
    logic [COEF_W-1:0]  cfg_fx;
    logic [COEF_W-1:0]  cfg_fy;
    logic [COEF_W-1:0]  cfg_zscale;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    t_point             expected_points[$];
    int                 mismatches  = 0;
    int                 points_seen = 0;

    // (pos - center) * z * inv_f, rounded half away from zero, saturated
    function automatic logic [POINT_W-1:0] axis_metres(input logic [COORD_W-1:0] pos,
                                                       input logic [PRINC_W-1:0] center,
                                                       input logic [POINT_W-1:0] z,
                                                       input logic [COEF_W-1:0]  inv_f);
        logic [PRINC_W-1:0] pos_q4;
        logic               below;
        logic [PRINC_W-1:0] offset;
        logic [65:0]        prod;
        logic [65:0]        q;
        pos_q4 = {pos, 4'b0000};
        below  = pos_q4 < center;
        offset = below ? center - pos_q4 : pos_q4 - center;
        prod   = 66'(offset) * 66'(z) * 66'(inv_f);
        q      = (prod + (66'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (below) begin
            if (q > NEG_SAT)
                q = NEG_SAT;
            q = -q;
        end else if (q > POS_SAT) begin
            q = POS_SAT;
        end
        return q[POINT_W-1:0];
    endfunction

    // Advances the raster position; returns 1 when the pixel yields a point.
    function automatic logic project_pixel(input t_pixel px, output t_point pt);
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [40:0]        z_full;
        logic [POINT_W-1:0] z;
        logic               hit;
        int                 limit;
        if (px.frame_start) begin
            col_pos = '0;
            row_pos = '0;
        end
        col = col_pos;
        row = row_pos;
        hit = (px.depth_raw != '0) && (int'(col) % SUBSAMPLE_STEP == 0)
              && (int'(row) % SUBSAMPLE_STEP == 0);

        z_full = (41'(px.depth_raw) * 41'(cfg_zscale) + 41'd128) >> 8;
        z      = (z_full > 41'hFFFFFF) ? '1 : z_full[POINT_W-1:0];
        pt.point_x   = axis_metres(col, cfg_cx, z, cfg_fx);
        pt.point_y   = axis_metres(row, cfg_cy, z, cfg_fy);
        pt.point_z   = z;
        pt.out_blue  = px.blue;
        pt.out_green = px.green;
        pt.out_red   = px.red;

        limit = (cfg_width == '0) ? 1 : int'(cfg_width);
        if (limit > MAX_COLUMNS)
            limit = MAX_COLUMNS;
        if (int'(col) + 1 >= limit) begin
            col_pos = '0;
            if (row != ROW_MAX)
                row_pos = row + 1'b1;
        end else begin
            col_pos = col + 1'b1;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: point %0d: %s", $time, points_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string field, input logic [POINT_W-1:0] want,
                                 input logic [POINT_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %h got %h", field, want, got));
    endtask

    always @(posedge i_clk) begin : watch
        t_point want;
        t_point got;
        if (!i_rst_n) begin
            cfg_width  = RST_IMAGE_WIDTH;
            cfg_cx     = RST_PRINCIPAL_X;
            cfg_cy     = RST_PRINCIPAL_Y;
            cfg_fx     = RST_INV_FOCAL_X;
            cfg_fy     = RST_INV_FOCAL_Y;
            cfg_zscale = RST_INV_DEPTH_SCALE;
            col_pos    = '0;
            row_pos    = '0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:     cfg_width  = i_cfg_data[WIDTH_W-1:0];
                    REG_PRINCIPAL_X:     cfg_cx     = i_cfg_data[PRINC_W-1:0];
                    REG_PRINCIPAL_Y:     cfg_cy     = i_cfg_data[PRINC_W-1:0];
                    REG_INV_FOCAL_X:     cfg_fx     = i_cfg_data[COEF_W-1:0];
                    REG_INV_FOCAL_Y:     cfg_fy     = i_cfg_data[COEF_W-1:0];
                    REG_INV_DEPTH_SCALE: cfg_zscale = i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                if (project_pixel(i_pix.data, want))
                    expected_points.insert(expected_points.size(), want);
            end
            if (i_pts.valid && i_pts.ready) begin
                got = i_pts.data;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point x %h y %h z %h",
                                              got.point_x, got.point_y, got.point_z));
                end else begin
                    want = expected_points.pop_front();
                    compare_field("point_x", want.point_x, got.point_x);
                    compare_field("point_y", want.point_y, got.point_y);
                    compare_field("point_z", want.point_z, got.point_z);
                    compare_field("out_blue", 24'(want.out_blue), 24'(got.out_blue));
                    compare_field("out_green", 24'(want.out_green), 24'(got.out_green));
                    compare_field("out_red", 24'(want.out_red), 24'(got.out_red));
                    points_seen++;
                end
            end
        end
        o_pending <= expected_points.size();
        o_errors  <= mismatches;
        o_points  <= points_seen;
    end

endmodule

### tb/depth_pixel_backprojection_tb.sv
// Top of the depth pixel back-projection testbench: clock, reset, register writes,
// pixel stimulus and output stalls. Checking is done by dpb_checker.
// Depends on dpb_pkg, dpb_if, dpb_checker and the block itself.
module depth_pixel_backprojection_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpb_pkg::*;

    localparam int IDLE_LIMIT    = 2000;   // cycles without any pixel or point transfer
    localparam int DRAIN_CYCLES  = 20;     // extra wait after the last predicted point leaves
    localparam int RANDOM_PIXELS = 1050;
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_SPARE = 3'd6;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    int                   idle_pct  = 0;
    int                   stall_pct = 0;
    int                   mismatch_count;
    int                   points_in_flight;
    int                   points_checked;

    dpb_pixel_if pix ();
    dpb_point_if pts ();

    depth_pixel_backprojection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .o_pts       (pts)
    );

    dpb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .i_pts       (pts),
        .o_errors    (mismatch_count),
        .o_pending   (points_in_flight),
        .o_points    (points_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        pts.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix.valid && pix.ready) || (pts.valid && pts.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic set_flow(input t_flow f);
        case (f)
            FLOW_FREE:        begin idle_pct = 0;  stall_pct = 0;  end
            FLOW_SRC_GAPS:    begin idle_pct = 46; stall_pct = 0;  end
            FLOW_SINK_STALLS: begin idle_pct = 0;  stall_pct = 46; end
            default:          begin idle_pct = 33; stall_pct = 33; end
        endcase
    endtask

    // Bits above the register width carry junk; the block must drop them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val, input int bits);
        logic [CFG_DAT_W-1:0] keep;
        keep = CFG_DAT_W'((64'd1 << bits) - 1);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= (CFG_DAT_W'($urandom) & ~keep) | (val & keep);
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic [WIDTH_W-1:0] w, input logic [PRINC_W-1:0] cx,
                             input logic [PRINC_W-1:0] cy, input logic [COEF_W-1:0] fx,
                             input logic [COEF_W-1:0] fy, input logic [COEF_W-1:0] zs);
        write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(w), WIDTH_W);
        write_reg(REG_PRINCIPAL_X, CFG_DAT_W'(cx), PRINC_W);
        write_reg(REG_PRINCIPAL_Y, CFG_DAT_W'(cy), PRINC_W);
        write_reg(REG_INV_FOCAL_X, fx, COEF_W);
        write_reg(REG_INV_FOCAL_Y, fy, COEF_W);
        write_reg(REG_INV_DEPTH_SCALE, zs, COEF_W);
        // unmapped index: must not disturb anything
        write_reg(IDX_FIRST_SPARE + CFG_IDX_W'($urandom_range(0, 1)), '0, 0);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PRINC_W-1:0] pick_center(input logic [PRINC_W-1:0] typical);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return PRINC_W'($urandom);
            default: return typical;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] typical);
        case ($urandom_range(0, 5))
            0:       return 24'd1;
            1:       return '1;
            2:       return COEF_W'($urandom_range(1, 24'hFFFFFF));
            default: return typical / 2 + COEF_W'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic randomize_cfg();
        logic [WIDTH_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = WIDTH_W'($urandom_range(0, 5));
            1:       w = WIDTH_W'(DEF_MAX_COLUMNS);
            2:       w = WIDTH_W'($urandom_range(DEF_MAX_COLUMNS + 1, 8191));
            3:       w = WIDTH_W'($urandom_range(1, DEF_MAX_COLUMNS));
            default: w = WIDTH_W'($urandom_range(4, 64));
        endcase
        apply_cfg(w, pick_center(RST_PRINCIPAL_X), pick_center(RST_PRINCIPAL_Y),
                  pick_coef(RST_INV_FOCAL_X), pick_coef(RST_INV_FOCAL_Y),
                  pick_coef(RST_INV_DEPTH_SCALE));
    endtask

    function automatic t_pixel make_pixel(input logic [DEPTH_W-1:0] depth,
                                          input logic [COLOR_W-1:0] b,
                                          input logic [COLOR_W-1:0] g,
                                          input logic [COLOR_W-1:0] r, input logic fs);
        t_pixel px;
        px.depth_raw   = depth;
        px.blue        = b;
        px.green       = g;
        px.red         = r;
        px.frame_start = fs;
        return px;
    endfunction

    function automatic t_pixel random_pixel();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(0, 9))
            0, 1:    depth = '0;
            2:       depth = '1;
            3:       depth = 16'd1;
            default: depth = DEPTH_W'($urandom);
        endcase
        return make_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                          $urandom_range(0, 49) == 0);
    endfunction

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(0, 99) < idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.data  <= px;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // Hold the sender until every predicted point has left the block.
    task automatic drain_points();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (points_in_flight != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int random_sent;
        int phase;
        int burst;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        pix.valid   = 1'b0;
        pix.data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: frame start at the origin, one off-grid pixel
        send_pixel(make_pixel(16'h8000, 8'h00, 8'hFF, 8'h5A, 1'b1));
        send_pixel(make_pixel(16'h1234, 8'hFF, 8'h00, 8'hA5, 1'b0));
        drain_points();

        // width zero acts as one: every pixel is a new row; z saturates
        apply_cfg(13'd0, 16'd16, 16'd40, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
        for (int k = 0; k <= 8; k++)
            send_pixel(make_pixel((k == 4) ? 16'd0 : 16'hFFFF - DEPTH_W'(k), COLOR_W'(k),
                                  ~COLOR_W'(k), COLOR_W'(k * 37), k == 0));
        drain_points();

        // width beyond the column limit; z rounding to zero still gives a point
        apply_cfg(13'd8191, 16'hFFFF, 16'd0, 24'd1, 24'hFFFFFF, 24'd1);
        send_pixel(make_pixel(16'd1, 8'h81, 8'h42, 8'h24, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 8'h7E, 8'hBD, 8'hDB, 1'b1));
        for (int k = 1; k <= 4; k++)
            send_pixel(make_pixel(16'h00FF, COLOR_W'(k), COLOR_W'(k), COLOR_W'(k), 1'b0));
        drain_points();

        // width shrunk under the current column: wraps right away
        apply_cfg(13'd1, 16'hFFFF, 16'd0, 24'd1, 24'hFFFFFF, 24'd1);
        for (int k = 0; k < 5; k++)
            send_pixel(make_pixel(16'h4321, 8'h11, 8'h22, 8'h33, 1'b0));
        drain_points();

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_PIXELS) begin
            set_flow(t_flow'(phase % 4));
            randomize_cfg();
            burst = $urandom_range(40, 160);
            for (int k = 0; k < burst; k++) begin
                send_pixel(random_pixel());
                random_sent++;
                if (phase == 1 && k == burst / 2)
                    drain_points();
            end
            drain_points();
            phase++;
        end

        if (mismatch_count == 0 && points_in_flight == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
